// ===== hw/rtl/falling_sand_grid_step_unit_macros.svh =====
// Assertion macros used by the falling sand grid checker.
`ifndef FALLING_SAND_GRID_STEP_UNIT_MACROS_SVH
`define FALLING_SAND_GRID_STEP_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define FSGS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define FSGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Check cons against ante with the delay given by n.
`define FSGS_ASSERT_DELAY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##n (cons)) else $error(msg);

`endif

// ===== hw/rtl/fsgs_pkg.sv =====
// Shared constants, op codes and memory control type of the falling sand grid.
`default_nettype none

package fsgs_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    localparam int OP_W     = 2;
    localparam int COORD_W  = 6;
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 3 * CHAN_W;
    // wide enough to hold the largest grid dimension for coordinate checks
    localparam int CMP_W    = 11;

    localparam logic [OP_W-1:0] OP_PLACE = 2'd0;
    localparam logic [OP_W-1:0] OP_PASS  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic full_we;
        logic full_wbit;
        logic color_we;
        logic rd_a_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/fsgs_grid_mem.sv =====
// Cell occupancy memory (two read ports) and cell color memory.
`default_nettype none

module fsgs_grid_mem #(
    parameter int ADDR_W = 12
) (
    input  wire                                i_clk,
    input  wire fsgs_pkg::t_mem_ctl            i_ctl,
    input  wire [ADDR_W-1:0]                   i_waddr,
    input  wire [ADDR_W-1:0]                   i_raddr_a,
    input  wire [ADDR_W-1:0]                   i_raddr_b,
    input  wire [fsgs_pkg::COLOR_W-1:0]        i_wcolor,
    output logic                               o_full_a,
    output logic                               o_full_b,
    output logic [fsgs_pkg::COLOR_W-1:0]       o_color
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic                          r_full_mem  [DEPTH];
    logic [fsgs_pkg::COLOR_W-1:0]  r_color_mem [DEPTH];
    logic                          r_full_a;
    logic                          r_full_b;
    logic [fsgs_pkg::COLOR_W-1:0]  r_color;

    always_ff @(posedge i_clk) begin
        if (i_ctl.full_we) begin
            r_full_mem[i_waddr] <= i_ctl.full_wbit;
        end
        if (i_ctl.rd_a_en) begin
            r_full_a <= r_full_mem[i_raddr_a];
        end
        r_full_b <= r_full_mem[i_raddr_b];
    end

    // hold read data unless port A is enabled
    always_ff @(posedge i_clk) begin
        if (i_ctl.color_we) begin
            r_color_mem[i_waddr] <= i_wcolor;
        end
        if (i_ctl.rd_a_en) begin
            r_color <= r_color_mem[i_raddr_a];
        end
    end

    assign o_full_a = r_full_a;
    assign o_full_b = r_full_b;
    assign o_color  = r_color;

endmodule

`default_nettype wire

// ===== hw/rtl/falling_sand_grid_step_unit.sv =====
// Falling sand grid step unit: command sequencer around the cell memories.
// A place or unused op goes through ST_PLACE, a read through ST_READ and ST_READ_W;
// a pass visits ST_RD and ST_EVAL for each scanned cell, plus ST_EVAL_L, ST_EVAL_R
// and ST_CLR as its neighbours require, and registers its result after the last cell.
// One item at a time; busy stays high until the item's result is registered.
// Synchronous reset starts a clearing sweep of all 2**(ROW_W+COL_W) cells (4096 at
// 64x64) with busy high; the result strobe lasts one cycle and is never stalled.
`default_nettype none

module falling_sand_grid_step_unit #(
    parameter int GRID_WIDTH  = fsgs_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = fsgs_pkg::GRID_HEIGHT_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire [fsgs_pkg::OP_W-1:0]         i_op,
    input  wire [fsgs_pkg::COORD_W-1:0]      i_cell_x,
    input  wire [fsgs_pkg::COORD_W-1:0]      i_cell_y,
    input  wire [fsgs_pkg::CHAN_W-1:0]       i_red_in,
    input  wire [fsgs_pkg::CHAN_W-1:0]       i_green_in,
    input  wire [fsgs_pkg::CHAN_W-1:0]       i_blue_in,
    output logic                             o_valid,
    output logic                             o_occupied,
    output logic [fsgs_pkg::CHAN_W-1:0]      o_red_out,
    output logic [fsgs_pkg::CHAN_W-1:0]      o_green_out,
    output logic [fsgs_pkg::CHAN_W-1:0]      o_blue_out,
    output logic                             o_any_moved
);

    // Cells live at address {row, col}; the memory is padded to a power of two
    // per dimension, and padding cells are never scanned or shown.
    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int ROW_W  = $clog2(GRID_HEIGHT);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int CW     = fsgs_pkg::CMP_W;
    localparam int CHW    = fsgs_pkg::CHAN_W;
    localparam int CLW    = fsgs_pkg::COLOR_W;

    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(GRID_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_START = ROW_W'(GRID_HEIGHT - 2);
    localparam logic [CW-1:0]    GRID_W_LIM = CW'(GRID_WIDTH);
    localparam logic [CW-1:0]    GRID_H_LIM = CW'(GRID_HEIGHT);

    // sequencer states
    localparam logic [3:0] ST_INIT   = 4'd0;  // clearing sweep after reset
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_PLACE  = 4'd2;  // place, or answer an unused op
    localparam logic [3:0] ST_READ   = 4'd3;  // issue read of the addressed cell
    localparam logic [3:0] ST_READ_W = 4'd4;  // read data back, register result
    localparam logic [3:0] ST_RD     = 4'd5;  // pass: read here and below
    localparam logic [3:0] ST_EVAL   = 4'd6;  // pass: test here, test below
    localparam logic [3:0] ST_EVAL_L = 4'd7;  // pass: test below-left
    localparam logic [3:0] ST_EVAL_R = 4'd8;  // pass: test below-right
    localparam logic [3:0] ST_CLR    = 4'd9;  // pass: empty the source cell

    logic [3:0]                   r_state,     n_state;
    logic [ADDR_W-1:0]            r_init_addr, n_init_addr;
    logic [fsgs_pkg::OP_W-1:0]    r_op,        n_op;
    logic [fsgs_pkg::COORD_W-1:0] r_x,         n_x;
    logic [fsgs_pkg::COORD_W-1:0] r_y,         n_y;
    logic [CLW-1:0]               r_color,     n_color;
    logic [ROW_W-1:0]             r_row,       n_row;
    logic [COL_W-1:0]             r_col,       n_col;
    logic                         r_moved,     n_moved;
    logic                         r_valid,     n_valid;
    logic                         r_occupied,  n_occupied;
    logic [CHW-1:0]               r_red,       n_red;
    logic [CHW-1:0]               r_green,     n_green;
    logic [CHW-1:0]               r_blue,      n_blue;
    logic                         r_any_moved, n_any_moved;

    fsgs_pkg::t_mem_ctl           mem_ctl;
    logic [ADDR_W-1:0]            mem_waddr;
    logic [ADDR_W-1:0]            mem_raddr_a;
    logic [ADDR_W-1:0]            mem_raddr_b;
    logic [CLW-1:0]               mem_wcolor;
    logic                         mem_full_a;
    logic                         mem_full_b;
    logic [CLW-1:0]               mem_color;

    logic                         in_grid;
    logic [ADDR_W-1:0]            cell_addr;
    logic [ADDR_W-1:0]            here_addr;
    logic [ADDR_W-1:0]            below_addr;
    logic [ADDR_W-1:0]            left_addr;
    logic [ADDR_W-1:0]            right_addr;
    logic                         col_end;
    logic                         row_end;
    logic                         advance;
    logic                         moved_now;

    // addressed cell of a place or read; out-of-grid coordinates are masked
    assign in_grid   = (CW'(r_x) < GRID_W_LIM) && (CW'(r_y) < GRID_H_LIM);
    assign cell_addr = {ROW_W'(r_y), COL_W'(r_x)};

    // scan neighborhood; the scan never reaches the bottom row as "here"
    assign here_addr  = {r_row, r_col};
    assign below_addr = {ROW_W'(r_row + 1'b1), r_col};
    assign left_addr  = {ROW_W'(r_row + 1'b1), COL_W'(r_col - 1'b1)};
    assign right_addr = {ROW_W'(r_row + 1'b1), COL_W'(r_col + 1'b1)};
    assign col_end    = (r_col == COL_LAST);
    assign row_end    = (r_row == '0);

    always_comb begin
        n_state     = r_state;
        n_init_addr = r_init_addr;
        n_op        = r_op;
        n_x         = r_x;
        n_y         = r_y;
        n_color     = r_color;
        n_row       = r_row;
        n_col       = r_col;
        n_moved     = r_moved;
        n_valid     = 1'b0;
        n_occupied  = r_occupied;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;
        n_any_moved = r_any_moved;

        mem_ctl     = '0;
        mem_waddr   = cell_addr;
        mem_raddr_a = cell_addr;
        mem_raddr_b = below_addr;
        mem_wcolor  = r_color;

        advance     = 1'b0;
        moved_now   = 1'b0;

        unique case (r_state)
            ST_INIT: begin
                // empty every cell, one per cycle
                mem_ctl.full_we = 1'b1;
                mem_waddr       = r_init_addr;
                n_init_addr     = r_init_addr + 1'b1;
                if (&r_init_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_op    = i_op;
                    n_x     = i_cell_x;
                    n_y     = i_cell_y;
                    n_color = {i_red_in, i_green_in, i_blue_in};
                    unique case (i_op)
                        fsgs_pkg::OP_PLACE: n_state = ST_PLACE;
                        fsgs_pkg::OP_READ:  n_state = ST_READ;
                        fsgs_pkg::OP_PASS: begin
                            n_row   = ROW_START;
                            n_col   = '0;
                            n_moved = 1'b0;
                            n_state = ST_RD;
                        end
                        default:            n_state = ST_PLACE;
                    endcase
                end
            end
            ST_PLACE: begin
                // a place on a full cell overwrites its color
                if (r_op == fsgs_pkg::OP_PLACE && in_grid) begin
                    mem_ctl.full_we   = 1'b1;
                    mem_ctl.full_wbit = 1'b1;
                    mem_ctl.color_we  = 1'b1;
                end
                n_valid     = 1'b1;
                n_occupied  = 1'b0;
                n_red       = '0;
                n_green     = '0;
                n_blue      = '0;
                n_any_moved = 1'b0;
                n_state     = ST_IDLE;
            end
            ST_READ: begin
                mem_ctl.rd_a_en = 1'b1;
                n_state         = ST_READ_W;
            end
            ST_READ_W: begin
                // an empty or out-of-grid cell reads as all zero
                n_valid     = 1'b1;
                n_occupied  = in_grid && mem_full_a;
                n_red       = (in_grid && mem_full_a) ? mem_color[CLW-1 -: CHW] : '0;
                n_green     = (in_grid && mem_full_a) ? mem_color[2*CHW-1 -: CHW] : '0;
                n_blue      = (in_grid && mem_full_a) ? mem_color[CHW-1:0] : '0;
                n_any_moved = 1'b0;
                n_state     = ST_IDLE;
            end
            ST_RD: begin
                mem_ctl.rd_a_en = 1'b1;
                mem_raddr_a     = here_addr;
                mem_raddr_b     = below_addr;
                n_state         = ST_EVAL;
            end
            ST_EVAL: begin
                if (!mem_full_a) begin
                    advance = 1'b1;
                end else if (!mem_full_b) begin
                    mem_ctl.full_we   = 1'b1;
                    mem_ctl.full_wbit = 1'b1;
                    mem_ctl.color_we  = 1'b1;
                    mem_waddr         = below_addr;
                    mem_wcolor        = mem_color;
                    n_state           = ST_CLR;
                end else if (r_col != '0) begin
                    mem_raddr_b = left_addr;
                    n_state     = ST_EVAL_L;
                end else if (!col_end) begin
                    mem_raddr_b = right_addr;
                    n_state     = ST_EVAL_R;
                end else begin
                    advance = 1'b1;
                end
            end
            ST_EVAL_L: begin
                if (!mem_full_b) begin
                    mem_ctl.full_we   = 1'b1;
                    mem_ctl.full_wbit = 1'b1;
                    mem_ctl.color_we  = 1'b1;
                    mem_waddr         = left_addr;
                    mem_wcolor        = mem_color;
                    n_state           = ST_CLR;
                end else if (!col_end) begin
                    mem_raddr_b = right_addr;
                    n_state     = ST_EVAL_R;
                end else begin
                    advance = 1'b1;
                end
            end
            ST_EVAL_R: begin
                if (!mem_full_b) begin
                    mem_ctl.full_we   = 1'b1;
                    mem_ctl.full_wbit = 1'b1;
                    mem_ctl.color_we  = 1'b1;
                    mem_waddr         = right_addr;
                    mem_wcolor        = mem_color;
                    n_state           = ST_CLR;
                end else begin
                    advance = 1'b1;
                end
            end
            ST_CLR: begin
                // the grain has landed; vacate its source
                mem_ctl.full_we = 1'b1;
                mem_waddr       = here_addr;
                moved_now       = 1'b1;
                advance         = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // step the scan: left to right, then one row up; finish after row 0
        if (advance) begin
            n_moved = r_moved | moved_now;
            if (col_end) begin
                n_col = '0;
                if (row_end) begin
                    n_valid     = 1'b1;
                    n_occupied  = 1'b0;
                    n_red       = '0;
                    n_green     = '0;
                    n_blue      = '0;
                    n_any_moved = r_moved | moved_now;
                    n_state     = ST_IDLE;
                end else begin
                    n_row   = r_row - 1'b1;
                    n_state = ST_RD;
                end
            end else begin
                n_col   = r_col + 1'b1;
                n_state = ST_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_init_addr <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_x         <= n_x;
        r_y         <= n_y;
        r_color     <= n_color;
        r_row       <= n_row;
        r_col       <= n_col;
        r_moved     <= n_moved;
        r_occupied  <= n_occupied;
        r_red       <= n_red;
        r_green     <= n_green;
        r_blue      <= n_blue;
        r_any_moved <= n_any_moved;
    end

    fsgs_grid_mem #(
        .ADDR_W (ADDR_W)
    ) u_grid_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_waddr   (mem_waddr),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .i_wcolor  (mem_wcolor),
        .o_full_a  (mem_full_a),
        .o_full_b  (mem_full_b),
        .o_color   (mem_color)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_occupied  = r_occupied;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;
    assign o_any_moved = r_any_moved;

endmodule

`default_nettype wire

// ===== hw/rtl/fsgs_checker.sv =====
// Port-level checks of the falling sand grid step unit, bound to the top level.
`default_nettype none

`include "falling_sand_grid_step_unit_macros.svh"

module fsgs_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          start,
    input wire                          busy,
    input wire [fsgs_pkg::OP_W-1:0]     i_op,
    input wire                          o_valid,
    input wire                          o_occupied,
    input wire [fsgs_pkg::CHAN_W-1:0]   o_red_out,
    input wire [fsgs_pkg::CHAN_W-1:0]   o_green_out,
    input wire [fsgs_pkg::CHAN_W-1:0]   o_blue_out,
    input wire                          o_any_moved
);

    logic accept;
    logic acc_place;
    logic acc_read;
    logic color_zero;

    assign accept     = start && !busy;
    assign acc_place  = accept && (i_op == fsgs_pkg::OP_PLACE);
    assign acc_read   = accept && (i_op == fsgs_pkg::OP_READ);
    assign color_zero = (o_red_out == '0) && (o_green_out == '0) && (o_blue_out == '0);

    `FSGS_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
    `FSGS_ASSERT_DELAY(a_place_result, acc_place, 2, o_valid, "place result missing")
    `FSGS_ASSERT_DELAY(a_read_result, acc_read, 3, o_valid, "read result missing")
    `FSGS_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe longer than one cycle")
    `FSGS_ASSERT_NOW(a_empty_color, o_valid && !o_occupied, color_zero, "color for empty cell")

    // a result word never reports a grain and a move together
    `FSGS_ASSERT_NOW(a_fields_apart, o_valid, !(o_occupied && o_any_moved), "occupied and moved")

endmodule

bind falling_sand_grid_step_unit fsgs_checker u_fsgs_checker (.*);

`default_nettype wire

// ===== tb/sand_check_pkg.sv =====
`timescale 1ns / 1ps
// Word types and the grain-tracking scoreboard for the falling sand grid testbench.
package sand_check_pkg;

    import fsgs_pkg::*;

    localparam int GRID_W = GRID_WIDTH_DEF;
    localparam int GRID_H = GRID_HEIGHT_DEF;

    // op code 3 is unused by the block
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } sand_cmd_t;

    typedef struct packed {
        logic              occupied;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              any_moved;
    } sand_answer_t;

    class grain_tracker;
        bit                 full  [GRID_H][GRID_W];
        bit [COLOR_W-1:0]   color [GRID_H][GRID_W];
        sand_answer_t       awaited[$];
        int                 mismatches;
        int                 grain_reads;
        int                 moving_passes;

        // One settling sweep: bottom-up rows, left to right, straight down first.
        function bit settle_grains();
            bit moved;
            int dst;
            moved = 1'b0;
            for (int row = GRID_H - 2; row >= 0; row--) begin
                for (int col = 0; col < GRID_W; col++) begin
                    if (!full[row][col])
                        continue;
                    dst = -1;
                    if (!full[row+1][col])
                        dst = col;
                    else if (col > 0 && !full[row+1][col-1])
                        dst = col - 1;
                    else if (col < GRID_W - 1 && !full[row+1][col+1])
                        dst = col + 1;
                    if (dst >= 0) begin
                        full[row+1][dst]  = 1'b1;
                        color[row+1][dst] = color[row][col];
                        full[row][col]    = 1'b0;
                        moved             = 1'b1;
                    end
                end
            end
            return moved;
        endfunction

        function void note_command(sand_cmd_t c);
            sand_answer_t ans;
            bit on_grid;
            ans     = '0;
            on_grid = (c.x < GRID_W) && (c.y < GRID_H);
            case (c.op)
                OP_PLACE: begin
                    if (on_grid) begin
                        full[c.y][c.x]  = 1'b1;
                        color[c.y][c.x] = {c.red, c.green, c.blue};
                    end
                end
                OP_PASS: begin
                    ans.any_moved = settle_grains();
                    if (ans.any_moved)
                        moving_passes++;
                end
                OP_READ: begin
                    if (on_grid && full[c.y][c.x]) begin
                        ans.occupied = 1'b1;
                        {ans.red, ans.green, ans.blue} = color[c.y][c.x];
                        grain_reads++;
                    end
                end
                default: ;
            endcase
            awaited.push_back(ans);
        endfunction

        function void report_mismatch(string what, logic [CHAN_W-1:0] want,
                                      logic [CHAN_W-1:0] got);
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
        endfunction

        function void check_answer(sand_answer_t got);
            sand_answer_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, actual 0x%0h", $time, got);
                return;
            end
            want = awaited.pop_front();
            if (got.occupied !== want.occupied)
                report_mismatch("occupied", CHAN_W'(want.occupied), CHAN_W'(got.occupied));
            if (got.red !== want.red)
                report_mismatch("red", want.red, got.red);
            if (got.green !== want.green)
                report_mismatch("green", want.green, got.green);
            if (got.blue !== want.blue)
                report_mismatch("blue", want.blue, got.blue);
            if (got.any_moved !== want.any_moved)
                report_mismatch("any_moved", CHAN_W'(want.any_moved), CHAN_W'(got.any_moved));
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top-level testbench for the falling sand grid step unit: stimulus, monitor and verdict.
module tb_top;

    import fsgs_pkg::*;
    import sand_check_pkg::*;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic [OP_W-1:0]      i_op        = OP_PLACE;
    logic [COORD_W-1:0]   i_cell_x    = '0;
    logic [COORD_W-1:0]   i_cell_y    = '0;
    logic [CHAN_W-1:0]    i_red_in    = '0;
    logic [CHAN_W-1:0]    i_green_in  = '0;
    logic [CHAN_W-1:0]    i_blue_in   = '0;
    logic                 busy;
    logic                 o_valid;
    logic                 o_occupied;
    logic [CHAN_W-1:0]    o_red_out;
    logic [CHAN_W-1:0]    o_green_out;
    logic [CHAN_W-1:0]    o_blue_out;
    logic                 o_any_moved;

    grain_tracker board;

    // Word mix counters for the closing summary.
    int sent_places;
    int sent_passes;
    int sent_reads;
    int sent_spares;

    // A pass walks the whole grid, so cap how many random ones run.
    int passes_left = 24;

    falling_sand_grid_step_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_cell_x    (i_cell_x),
        .i_cell_y    (i_cell_y),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_valid     (o_valid),
        .o_occupied  (o_occupied),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_any_moved (o_any_moved)
    );

    always #2 i_clk = ~i_clk;

    // Take each result word at the edge that ends its strobe cycle; the values seen
    // here are the ones held before the edge, so no ordering within the step matters.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            board.check_answer({o_occupied, o_red_out, o_green_out, o_blue_out, o_any_moved});
    end

    function automatic sand_cmd_t make_word(logic [OP_W-1:0] op, int x, int y,
                                            logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                            logic [CHAN_W-1:0] b);
        sand_cmd_t c;
        c.op    = op;
        c.x     = x[COORD_W-1:0];
        c.y     = y[COORD_W-1:0];
        c.red   = r;
        c.green = g;
        c.blue  = b;
        return c;
    endfunction

    // Random word: mostly grains dropped into three narrow piles (left edge, middle,
    // right edge) low in the grid so they stack and slide, reads aimed at the top
    // grain of a pile column, some passes, and a share of noise anywhere.
    function automatic sand_cmd_t random_word();
        sand_cmd_t c;
        int pick;
        int row;
        int pile;
        c.red   = CHAN_W'($urandom);
        c.green = CHAN_W'($urandom);
        c.blue  = CHAN_W'($urandom);
        c.x     = COORD_W'($urandom);
        c.y     = COORD_W'($urandom);
        pile    = $urandom_range(2);
        pick    = $urandom_range(99);
        if (pick < 5) begin
            c.op = OP_SPARE;
        end else if (pick < 20 && passes_left > 0) begin
            c.op = OP_PASS;
            passes_left--;
        end else if (pick < 60) begin
            c.op = OP_PLACE;
            if ($urandom_range(99) < 80) begin
                c.x = COORD_W'((pile == 0) ? $urandom_range(5) :
                               (pile == 1) ? $urandom_range(63, 58) : $urandom_range(34, 29));
                c.y = COORD_W'($urandom_range(63, 50));
            end
        end else begin
            c.op = OP_READ;
            if ($urandom_range(99) < 70) begin
                c.x = COORD_W'((pile == 0) ? $urandom_range(5) :
                               (pile == 1) ? $urandom_range(63, 58) : $urandom_range(34, 29));
                row = 0;
                while (row < GRID_H && !board.full[row][c.x])
                    row++;
                if (row < GRID_H)
                    c.y = COORD_W'(row);
            end
        end
        return c;
    endfunction

    // Present one word and hold it until the block takes it. Start is left high on
    // acceptance: the next call either keeps it high or drops it for a gap, so it
    // never gets two assignments in one step.
    task automatic send_word(input sand_cmd_t c, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_op       <= c.op;
        i_cell_x   <= c.x;
        i_cell_y   <= c.y;
        i_red_in   <= c.red;
        i_green_in <= c.green;
        i_blue_in  <= c.blue;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        board.note_command(c);
        case (c.op)
            OP_PLACE: sent_places++;
            OP_PASS:  sent_passes++;
            OP_READ:  sent_reads++;
            default:  sent_spares++;
        endcase
    endtask

    // Drop start and hold off until every expected result word has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.awaited.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        sand_cmd_t directed[$];
        int idle_pct;

        board = new();

        // Hold reset, then release it; the block then clears the grid with busy high.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a pass on an empty grid, reads of empty cells, grains on the
        // bottom row and both edges, a grain with every move blocked, a top-row
        // grain, an overwrite of a full cell, the unused op with all fields high.
        directed.push_back(make_word(OP_PASS,   0,  0, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_word(OP_READ,   0,  0, 8'hff, 8'hff, 8'hff));
        directed.push_back(make_word(OP_PLACE, 63, 63, 8'hff, 8'hff, 8'hff));
        directed.push_back(make_word(OP_PLACE,  0, 63, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_word(OP_PLACE,  0, 62, 8'haa, 8'h55, 8'haa));
        directed.push_back(make_word(OP_PLACE, 63, 62, 8'h55, 8'haa, 8'h55));
        directed.push_back(make_word(OP_PLACE, 10, 63, 8'h01, 8'h02, 8'h03));
        directed.push_back(make_word(OP_PLACE,  9, 63, 8'h04, 8'h05, 8'h06));
        directed.push_back(make_word(OP_PLACE, 11, 63, 8'h07, 8'h08, 8'h09));
        directed.push_back(make_word(OP_PLACE, 10, 62, 8'h80, 8'h40, 8'h20));
        directed.push_back(make_word(OP_PLACE,  0,  0, 8'h12, 8'h34, 8'h56));
        directed.push_back(make_word(OP_PLACE,  0,  0, 8'hfe, 8'hdc, 8'hba));
        directed.push_back(make_word(OP_SPARE, 63, 63, 8'hff, 8'hff, 8'hff));
        directed.push_back(make_word(OP_READ,  63, 63, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_word(OP_READ,   0, 63, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_word(OP_PASS,  63, 63, 8'hff, 8'hff, 8'hff));
        directed.push_back(make_word(OP_READ,   1, 63, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_word(OP_READ,  62, 63, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_word(OP_READ,  10, 62, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_word(OP_READ,   0,  1, 8'h00, 8'h00, 8'h00));
        directed.push_back(make_word(OP_READ,   0,  0, 8'h00, 8'h00, 8'h00));
        foreach (directed[i])
            send_word(directed[i], 0);
        wait_drained();

        // Random part in three stretches: light sender gaps, heavy sender gaps,
        // then back-to-back. Drain fully between stretches.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 10 : (phase == 1) ? 51 : 0;
            for (int n = 0; n < 26; n++)
                send_word(random_word(), idle_pct);
            wait_drained();
        end

        // Wait for any stray result strobe before the summary.
        repeat (16) @(posedge i_clk);

        $display("Sent %0d places, %0d passes, %0d reads, %0d unused-op words.",
                 sent_places, sent_passes, sent_reads, sent_spares);
        $display("Reads that found a grain: %0d; passes that moved grains: %0d; mismatches: %0d.",
                 board.grain_reads, board.moving_passes, board.mismatches);
        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: a time limit several times the slowest legal run.
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
